>>> rtl/sff_pkg.sv
// shared types and constants of the two-level spill fifo
// no dependencies; imported by every module of the block
package sff_pkg;

	// word and store geometry
	localparam int WORD_W      = 32;
	localparam int INNER_DEPTH = 16;
	localparam int OUTER_DEPTH = 1024;
	localparam int IIW         = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;
	localparam int ICW         = $clog2(INNER_DEPTH + 1);
	localparam int OIW         = (OUTER_DEPTH > 1) ? $clog2(OUTER_DEPTH) : 1;
	localparam int OCW         = $clog2(OUTER_DEPTH + 1);

	// command queue between front and back
	localparam int CMD_DEPTH = 2;
	localparam int CPW       = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CCW       = $clog2(CMD_DEPTH + 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int ILIM_W     = 5;
	localparam int ELIM_W     = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_LIMIT = 2'd1;
	localparam logic [ILIM_W-1:0]    INT_LIMIT_RST      = 5'd16;
	localparam logic [ELIM_W-1:0]    EXT_LIMIT_RST      = 11'd1024;

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_PUSHED = 2'd0;
	localparam logic [1:0] ST_POPPED = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// word returned by a pop on an empty fifo
	localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

	typedef struct packed {
		logic                     op;
		logic signed [WORD_W-1:0] data;
	} cmd_t;

endpackage

>>> rtl/spill_fifo_two_level_top.sv
// Two-level spill fifo: push/pop words are accepted into the command queue first.
// Results are registered; push and non-refill pop sustain 1 word/cycle unless a held
// result (out_ready low) or a refill stalls them. A pop that finds the internal ring
// empty first refills n = min(overflow fill, limit) words with n overflow memory reads,
// so its result comes later than that of a plain pop.
// Asynchronous reset clears counts and pointers and sets the limits to their reset values; stores are not cleared.
module spill_fifo_two_level_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic signed [31:0]               data_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [31:0]               data_out,
	output logic [1:0]                       status,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sff_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sff_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sff_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	// input side and command queue
	sff_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.data_in   (data_in),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// execution side
	sff_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_out  (data_out),
		.status    (status)
	);

endmodule

>>> rtl/sff_front.sv
// front end: accepts input words, decodes the operation, queues commands
// depends on sff_pkg
module sff_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic signed [31:0]         data_in,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output sff_pkg::cmd_t              cmd
);
	import sff_pkg::*;

	cmd_t            cmd_mem_q [CMD_DEPTH];
	logic [CPW-1:0]  wr_ptr_q;
	logic [CPW-1:0]  rd_ptr_q;
	logic [CCW-1:0]  fill_q;
	logic            push;
	logic            pop;
	cmd_t            cmd_in;

	// classify the incoming word
	always_comb begin
		cmd_in.op   = mode ? OP_POP : OP_PUSH;
		cmd_in.data = data_in;
	end

	assign in_ready  = (fill_q != CCW'(CMD_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = cmd_mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CPW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + CPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CPW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + CPW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CCW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CCW'(1);
			end
		end
	end

endmodule

>>> rtl/sff_back.sv
// back end: limit registers, internal ring, overflow memory, refill sequencer
// and result register; depends on sff_pkg
module sff_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  sff_pkg::cmd_t                    cmd,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sff_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sff_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [31:0]               data_out,
	output logic [1:0]                       status
);
	import sff_pkg::*;

	localparam logic FSM_IDLE   = 1'b0;
	localparam logic FSM_REFILL = 1'b1;

	// configuration
	logic [ILIM_W-1:0] int_limit_q;
	logic [ELIM_W-1:0] ext_limit_q;

	// ring state
	logic signed [WORD_W-1:0] inner_mem_q [INNER_DEPTH];
	logic signed [WORD_W-1:0] outer_mem_q [OUTER_DEPTH];
	logic [IIW-1:0]           inner_head_q;
	logic [ICW-1:0]           inner_count_q;
	logic [OIW-1:0]           outer_head_q;
	logic [OCW-1:0]           outer_count_q;

	// refill sequencer
	logic                     state_q;
	logic [ICW-1:0]           refill_cnt_q;
	logic                     rd_vld_s1;
	logic signed [WORD_W-1:0] outer_rdata_s1;

	// result register
	logic                     res_valid_q;
	logic signed [WORD_W-1:0] data_out_q;
	logic [1:0]               status_q;

	logic [ICW-1:0]           ilim;
	logic [OCW-1:0]           olim;
	logic [ICW-1:0]           refill_n;
	logic [ICW:0]             inner_sum;
	logic [IIW-1:0]           inner_slot;
	logic [OCW:0]             outer_sum;
	logic [OIW-1:0]           outer_slot;
	logic [IIW-1:0]           inner_head_nx;
	logic [OIW-1:0]           outer_head_nx;
	logic                     issue;
	logic                     is_push;
	logic                     inner_room;
	logic                     push_inner;
	logic                     push_outer;
	logic                     push_full;
	logic                     pop_inner;
	logic                     pop_empty;
	logic                     start_refill;
	logic                     res_load;
	logic                     refill_rd;
	logic                     inner_we;
	logic signed [WORD_W-1:0] inner_wdata;

	assign cfg_ready = 1'b1;
	assign out_valid = res_valid_q;
	assign data_out  = data_out_q;
	assign status    = status_q;

	// effective limits, saturated to the store depths (a zero internal limit counts as one), and refill length
	always_comb begin
		if (int_limit_q == '0) begin
			ilim = ICW'(1);
		end else if (32'(int_limit_q) > 32'(INNER_DEPTH)) begin
			ilim = ICW'(INNER_DEPTH);
		end else begin
			ilim = ICW'(int_limit_q);
		end
		if (32'(ext_limit_q) > 32'(OUTER_DEPTH)) begin
			olim = OCW'(OUTER_DEPTH);
		end else begin
			olim = OCW'(ext_limit_q);
		end
		if (32'(outer_count_q) < 32'(ilim)) begin
			refill_n = ICW'(outer_count_q);
		end else begin
			refill_n = ilim;
		end
	end

	// tail slots and head increments with wrap
	always_comb begin
		inner_sum  = (ICW + 1)'(inner_head_q) + (ICW + 1)'(inner_count_q);
		inner_slot = (inner_sum >= (ICW + 1)'(INNER_DEPTH)) ?
			IIW'(inner_sum - (ICW + 1)'(INNER_DEPTH)) : IIW'(inner_sum);
		outer_sum  = (OCW + 1)'(outer_head_q) + (OCW + 1)'(outer_count_q);
		outer_slot = (outer_sum >= (OCW + 1)'(OUTER_DEPTH)) ?
			OIW'(outer_sum - (OCW + 1)'(OUTER_DEPTH)) : OIW'(outer_sum);
		inner_head_nx = (inner_head_q == IIW'(INNER_DEPTH - 1)) ? '0 : inner_head_q + IIW'(1);
		outer_head_nx = (outer_head_q == OIW'(OUTER_DEPTH - 1)) ? '0 : outer_head_q + OIW'(1);
	end

	// command decode against the current fill
	always_comb begin
		issue        = (state_q == FSM_IDLE) && cmd_valid && (!res_valid_q || out_ready);
		is_push      = (cmd.op == OP_PUSH);
		inner_room   = (inner_count_q < ilim) && (outer_count_q == '0);
		push_inner   = issue && is_push && inner_room;
		push_outer   = issue && is_push && !inner_room && (outer_count_q < olim);
		push_full    = issue && is_push && !inner_room && !(outer_count_q < olim);
		pop_inner    = issue && !is_push && (inner_count_q != '0);
		pop_empty    = issue && !is_push && (inner_count_q == '0) && (outer_count_q == '0);
		start_refill = issue && !is_push && (inner_count_q == '0) && (outer_count_q != '0);
		res_load     = issue && !start_refill;
		cmd_ready    = res_load;
		refill_rd    = (state_q == FSM_REFILL) && (refill_cnt_q != '0);
		inner_we     = push_inner || rd_vld_s1;
		inner_wdata  = rd_vld_s1 ? outer_rdata_s1 : cmd.data;
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_limit_q <= INT_LIMIT_RST;
			ext_limit_q <= EXT_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INTERNAL_LIMIT: int_limit_q <= cfg_data[ILIM_W-1:0];
				CFG_EXTERNAL_LIMIT: ext_limit_q <= cfg_data[ELIM_W-1:0];
				default: ;
			endcase
		end
	end

	// internal ring storage
	always_ff @(posedge clk) begin
		if (inner_we) begin
			inner_mem_q[inner_slot] <= inner_wdata;
		end
	end

	// overflow memory, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (push_outer) begin
			outer_mem_q[outer_slot] <= cmd.data;
		end
		if (refill_rd) begin
			outer_rdata_s1 <= outer_mem_q[outer_head_q];
		end
	end

	// ring pointers, counts and refill sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_head_q  <= '0;
			inner_count_q <= '0;
			outer_head_q  <= '0;
			outer_count_q <= '0;
			state_q       <= FSM_IDLE;
			refill_cnt_q  <= '0;
			rd_vld_s1     <= 1'b0;
		end else begin
			if (inner_we) begin
				inner_count_q <= inner_count_q + ICW'(1);
			end else if (pop_inner) begin
				inner_count_q <= inner_count_q - ICW'(1);
			end
			if (pop_inner) begin
				inner_head_q <= inner_head_nx;
			end
			if (push_outer) begin
				outer_count_q <= outer_count_q + OCW'(1);
			end else if (refill_rd) begin
				outer_count_q <= outer_count_q - OCW'(1);
			end
			if (refill_rd) begin
				outer_head_q <= outer_head_nx;
			end
			rd_vld_s1 <= refill_rd;
			unique case (state_q)
				FSM_IDLE: begin
					if (start_refill) begin
						state_q      <= FSM_REFILL;
						refill_cnt_q <= refill_n;
					end
				end
				FSM_REFILL: begin
					if (refill_rd) begin
						refill_cnt_q <= refill_cnt_q - ICW'(1);
					end else if (!rd_vld_s1) begin
						state_q <= FSM_IDLE;
					end
				end
				default: state_q <= FSM_IDLE;
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			priority if (pop_inner) begin
				data_out_q <= inner_mem_q[inner_head_q];
				status_q   <= ST_POPPED;
			end else if (pop_empty) begin
				data_out_q <= EMPTY_WORD;
				status_q   <= ST_EMPTY;
			end else if (push_full) begin
				data_out_q <= '0;
				status_q   <= ST_FULL;
			end else begin
				data_out_q <= '0;
				status_q   <= ST_PUSHED;
			end
		end
	end

	// fills stay within the store depths
	a_inner_fill: assert property (@(posedge clk) disable iff (!arst_n)
		inner_count_q <= ICW'(INNER_DEPTH))
		else $error("internal ring overfilled");

	a_outer_fill: assert property (@(posedge clk) disable iff (!arst_n)
		outer_count_q <= OCW'(OUTER_DEPTH))
		else $error("overflow ring overfilled");

	// refill reads only come back while the sequencer runs
	a_refill_rd: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == FSM_REFILL))
		else $error("overflow read returned outside refill");

	// refill starts only with an empty internal ring
	a_refill_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_refill |=> (state_q == FSM_REFILL) && (inner_count_q == '0))
		else $error("refill started on a non-empty internal ring");

	// a drained refill returns to idle
	a_refill_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_REFILL) && (refill_cnt_q == '0) && !rd_vld_s1 |=>
		(state_q == FSM_IDLE))
		else $error("refill sequencer did not finish");

endmodule
